### src/vtbb_pkg.sv
package vtbb_pkg;

  localparam int DIM_BITS_DEF    = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS      = 31;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  // register index, byte address is 4 * index
  localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_MODE      = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COLUMNS   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_ROWS      = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FRAMES    = 3'd4;

  localparam int MODE_BITS = 3;
  localparam logic [MODE_BITS-1:0] MODE_EQ = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_GT = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_GE = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_LT = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_LE = 3'd4;

endpackage

### src/volume_threshold_bounding_box_core.sv
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | in_tdata: voxel_value
// out_    | out | out_tvalid/tready   | out_tdata: box and count, out_tuser: included,
//         |     |                     | out_tlast: volume_done
// cfg_    | in  | APB psel/penable    | threshold, compare_mode, columns, rows, frames
//
// One voxel per cycle while in_tready is high: compare, position counters and
// min/max/count update are one combinational pass from the input port into the
// result register; out_tvalid rises in the cycle after an accept. A held
// result stalls intake only when out_tready is low: in_tready is !out_tvalid |
// out_tready. rst_n (synchronous) resets all but the result payload registers.
module volume_threshold_bounding_box_core #(
  parameter int DIM_BITS    = vtbb_pkg::DIM_BITS_DEF,
  parameter int SAMPLE_BITS = vtbb_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [SAMPLE_BITS-1:0] voxel_value
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,

  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // x_low, x_high, y_low, y_high, z_low, z_high, voxel_count (lowest first)
  output logic [((3*(2*DIM_BITS+1)+vtbb_pkg::COUNT_BITS+7)/8)*8-1:0] out_tdata,
  // included
  output logic                                 out_tuser,
  output logic                                 out_tlast,

  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [vtbb_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [vtbb_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [vtbb_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int DB     = DIM_BITS;
  localparam int SB     = SAMPLE_BITS;
  localparam int CB     = vtbb_pkg::COUNT_BITS;
  localparam int DW     = vtbb_pkg::CFG_DATA_BITS;
  localparam int PACK_W = 3 * (2 * DB + 1) + CB;
  localparam int OUT_W  = ((PACK_W + 7) / 8) * 8;
  localparam logic [DB:0] DIM_MAX = (DB + 1)'(1) << DB;

  // configuration
  logic [SB-1:0]                       threshold_r;
  logic [vtbb_pkg::MODE_BITS-1:0]      mode_r;
  logic [DB:0]                         columns_r, rows_r, frames_r;

  // volume state
  logic [DB-1:0] x_pos_r, y_pos_r, z_pos_r;
  logic [DB:0]   x_min_r, y_min_r, z_min_r;
  logic [DB-1:0] x_max_r, y_max_r, z_max_r;
  logic [CB-1:0] count_r;

  // result register
  logic          out_valid_r;
  logic          out_incl_r, out_done_r;
  logic [OUT_W-1:0] out_data_r;

  logic in_accept;
  logic cfg_write;
  logic [vtbb_pkg::REG_IDX_BITS-1:0] cfg_idx;

  function automatic logic [DB:0] eff_dim(input logic [DB:0] d);
    logic [DB:0] r;
    if (d == '0) begin
      r = (DB + 1)'(1);
    end else if (d > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_incl_r;
  assign out_tlast  = out_done_r;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[vtbb_pkg::CFG_ADDR_BITS-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      vtbb_pkg::REG_THRESHOLD: cfg_prdata = DW'(threshold_r);
      vtbb_pkg::REG_MODE:      cfg_prdata = DW'(mode_r);
      vtbb_pkg::REG_COLUMNS:   cfg_prdata = DW'(columns_r);
      vtbb_pkg::REG_ROWS:      cfg_prdata = DW'(rows_r);
      vtbb_pkg::REG_FRAMES:    cfg_prdata = DW'(frames_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // per-voxel datapath
  logic [DB:0]   cx, cy, cz;
  logic signed [SB-1:0] smp, thr;
  logic          incl, first, last_x, last_y, last_z, done;
  logic [DB:0]   xmin, ymin, zmin;
  logic [DB-1:0] xmax, ymax, zmax;
  logic [CB-1:0] cnt;
  logic [PACK_W-1:0] pack;

  always_comb begin
    cx  = eff_dim(columns_r);
    cy  = eff_dim(rows_r);
    cz  = eff_dim(frames_r);
    smp = $signed(in_tdata[SB-1:0]);
    thr = $signed(threshold_r);

    unique case (mode_r)
      vtbb_pkg::MODE_EQ: incl = (smp == thr);
      vtbb_pkg::MODE_GT: incl = (smp >  thr);
      vtbb_pkg::MODE_GE: incl = (smp >= thr);
      vtbb_pkg::MODE_LT: incl = (smp <  thr);
      vtbb_pkg::MODE_LE: incl = (smp <= thr);
      default:           incl = 1'b0;
    endcase

    // all positions zero: summary restarts from the current dimensions
    first = (x_pos_r == '0) && (y_pos_r == '0) && (z_pos_r == '0);
    if (first) begin
      xmin = cx;  ymin = cy;  zmin = cz;
      xmax = '0;  ymax = '0;  zmax = '0;
      cnt  = '0;
    end else begin
      xmin = x_min_r;  ymin = y_min_r;  zmin = z_min_r;
      xmax = x_max_r;  ymax = y_max_r;  zmax = z_max_r;
      cnt  = count_r;
    end

    if (incl) begin
      if ({1'b0, x_pos_r} < xmin) xmin = {1'b0, x_pos_r};
      if ({1'b0, y_pos_r} < ymin) ymin = {1'b0, y_pos_r};
      if ({1'b0, z_pos_r} < zmin) zmin = {1'b0, z_pos_r};
      if (x_pos_r > xmax) xmax = x_pos_r;
      if (y_pos_r > ymax) ymax = y_pos_r;
      if (z_pos_r > zmax) zmax = z_pos_r;
      if (cnt != '1) cnt = cnt + CB'(1);
    end

    // >= so a dimension shrunk mid-volume wraps at once
    last_x = {1'b0, x_pos_r} >= (cx - (DB + 1)'(1));
    last_y = {1'b0, y_pos_r} >= (cy - (DB + 1)'(1));
    last_z = {1'b0, z_pos_r} >= (cz - (DB + 1)'(1));
    done   = last_x && last_y && last_z;

    pack = {cnt, zmax, zmin, ymax, ymin, xmax, xmin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      mode_r      <= vtbb_pkg::MODE_EQ;
      columns_r   <= DIM_MAX;
      rows_r      <= DIM_MAX;
      frames_r    <= DIM_MAX;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        vtbb_pkg::REG_THRESHOLD: threshold_r <= cfg_pwdata[SB-1:0];
        vtbb_pkg::REG_MODE:      mode_r      <= cfg_pwdata[vtbb_pkg::MODE_BITS-1:0];
        vtbb_pkg::REG_COLUMNS:   columns_r   <= cfg_pwdata[DB:0];
        vtbb_pkg::REG_ROWS:      rows_r      <= cfg_pwdata[DB:0];
        vtbb_pkg::REG_FRAMES:    frames_r    <= cfg_pwdata[DB:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r <= '0;  y_pos_r <= '0;  z_pos_r <= '0;
      x_min_r <= DIM_MAX;  y_min_r <= DIM_MAX;  z_min_r <= DIM_MAX;
      x_max_r <= '0;  y_max_r <= '0;  z_max_r <= '0;
      count_r <= '0;
    end else if (in_accept) begin
      if (done) begin
        x_pos_r <= '0;  y_pos_r <= '0;  z_pos_r <= '0;
        x_min_r <= cx;  y_min_r <= cy;  z_min_r <= cz;
        x_max_r <= '0;  y_max_r <= '0;  z_max_r <= '0;
        count_r <= '0;
      end else begin
        x_min_r <= xmin;  y_min_r <= ymin;  z_min_r <= zmin;
        x_max_r <= xmax;  y_max_r <= ymax;  z_max_r <= zmax;
        count_r <= cnt;
        if (!last_x) begin
          x_pos_r <= x_pos_r + DB'(1);
        end else begin
          x_pos_r <= '0;
          if (!last_y) begin
            y_pos_r <= y_pos_r + DB'(1);
          end else begin
            y_pos_r <= '0;
            z_pos_r <= z_pos_r + DB'(1);
          end
        end
      end
    end
  end

  logic out_valid_nxt;

  always_comb begin
    priority if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_incl_r <= incl;
      out_done_r <= done;
      out_data_r <= OUT_W'(pack);
    end
  end

  // end of volume restarts the position counters
  a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && done |=> (x_pos_r == '0) && (y_pos_r == '0) && (z_pos_r == '0))
    else $error("position counters not cleared after volume end");

  // an included voxel gives x_low <= x_high and a nonzero count
  a_incl_box: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && incl |=> (out_data_r[DB:0] <= {1'b0, out_data_r[2*DB:DB+1]})
      && (out_data_r[PACK_W-1:PACK_W-CB] != '0))
    else $error("included voxel outside its bounding box");

  // a held result blocks intake
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("request accepted over a stalled result");

endmodule
